// ===== rtl/core/slip_receive_deframer_defines.svh =====
// Assertion macros for the SLIP receive deframer.
// No dependencies; included by the top level only.
`ifndef SLIP_RECEIVE_DEFRAMER_DEFINES_SVH
`define SLIP_RECEIVE_DEFRAMER_DEFINES_SVH
`ifndef SYNTHESIS
`define SRD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SRD_ASSERT_SAME(lbl, ante, cons, msg)
`define SRD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/srd_pkg.sv =====
// Shared types and constants of the SLIP receive deframer.
// No dependencies; used by every module of the block but srd_in_stage.
package srd_pkg;

  localparam int unsigned MAX_FRAME_CAP_DEF = 131068;
  localparam int unsigned LEN_W = 17;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SIXBIT_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_CHAR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_END_CHAR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_ESC_CHAR = 3'd5;

  // Six-bit character set.
  localparam logic [7:0] SIX_BASE = 8'h30;
  localparam logic [7:0] SIX_END  = 8'h70;

  typedef enum logic [2:0] {
    EV_DATA    = 3'd0,
    EV_COMMIT  = 3'd1,
    EV_DISCARD = 3'd2,
    EV_OVERRUN = 3'd3,
    EV_LINEERR = 3'd4
  } srd_event_e;

  typedef struct packed {
    logic             sixbit_mode;
    logic [LEN_W-1:0] max_frame_len;
    logic [7:0]       end_char;
    logic [7:0]       esc_char;
    logic [7:0]       esc_end_char;
    logic [7:0]       esc_esc_char;
  } srd_cfg_t;

  typedef struct packed {
    srd_event_e       event_res;
    logic [7:0]       data;
    logic [LEN_W-1:0] frame_length;
  } srd_result_t;

endpackage

// ===== rtl/core/srd_cfg_regs.sv =====
// Configuration register file of the SLIP receive deframer.
// Depends on srd_pkg.
module srd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [srd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [srd_pkg::LEN_W-1:0]      cfg_wdata_i,
  output srd_pkg::srd_cfg_t              cfg_o
);

  srd_pkg::srd_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        srd_pkg::CFG_SIXBIT_MODE:  cfg_d.sixbit_mode   = cfg_wdata_i[0];
        srd_pkg::CFG_MAX_FRAME:    cfg_d.max_frame_len = cfg_wdata_i;
        srd_pkg::CFG_END_CHAR:     cfg_d.end_char      = cfg_wdata_i[7:0];
        srd_pkg::CFG_ESC_CHAR:     cfg_d.esc_char      = cfg_wdata_i[7:0];
        srd_pkg::CFG_ESC_END_CHAR: cfg_d.esc_end_char  = cfg_wdata_i[7:0];
        srd_pkg::CFG_ESC_ESC_CHAR: cfg_d.esc_esc_char  = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sixbit_mode   <= 1'b0;
      cfg_q.max_frame_len <= 17'd1152;
      cfg_q.end_char      <= 8'd192;
      cfg_q.esc_char      <= 8'd219;
      cfg_q.esc_end_char  <= 8'd220;
      cfg_q.esc_esc_char  <= 8'd221;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/srd_in_stage.sv =====
// Input register of the SLIP receive deframer.
// Depends on nothing but the port list; holds one received byte until decoded.
module srd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       line_error_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] rx_byte_o,
  output logic       line_error_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       lerr_q;
  logic       load;

  // The slot frees up in the same cycle that its byte is decoded.
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
      lerr_q <= line_error_i;
    end
  end

  assign valid_o      = valid_q;
  assign rx_byte_o    = byte_q;
  assign line_error_o = lerr_q;

endmodule

// ===== rtl/core/srd_decode.sv =====
// Per-byte SLIP and six-bit decoder with the frame state registers.
// Depends on srd_pkg.
module srd_decode #(
  parameter int unsigned MAX_FRAME_CAP = srd_pkg::MAX_FRAME_CAP_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srd_pkg::srd_cfg_t   cfg_i,
  input  logic                fire_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                line_error_i,
  output logic                res_valid_o,
  output srd_pkg::srd_result_t res_o
);

  localparam logic [srd_pkg::LEN_W-1:0] CapLen = srd_pkg::LEN_W'(MAX_FRAME_CAP);

  logic [srd_pkg::LEN_W-1:0] count_q, count_d, limit;
  logic                      esc_q, esc_d;
  logic                      sticky_q, sticky_d;
  logic [13:0]               acc_q, acc_d, acc_new;
  logic [3:0]                bits_q, bits_d, bits_sum, bits_left;
  logic [5:0]                six_val;
  logic                      frame_end, take_byte;
  logic [7:0]                byte_val;

  assign limit = (cfg_i.max_frame_len > CapLen) ? CapLen : cfg_i.max_frame_len;

  assign six_val   = 6'(rx_byte_i - srd_pkg::SIX_BASE);
  assign acc_new   = {acc_q[7:0], six_val};
  assign bits_sum  = bits_q + 4'd6;
  assign bits_left = bits_sum - 4'd8;

  always_comb begin
    count_d     = count_q;
    esc_d       = esc_q;
    sticky_d    = sticky_q;
    acc_d       = acc_q;
    bits_d      = bits_q;
    frame_end   = 1'b0;
    take_byte   = 1'b0;
    byte_val    = rx_byte_i;
    res_valid_o = 1'b0;
    res_o       = '{event_res: srd_pkg::EV_DATA, data: 8'd0, frame_length: '0};

    if (fire_i) begin
      if (line_error_i) begin
        // Only the first error of a frame is reported.
        if (!sticky_q) begin
          sticky_d        = 1'b1;
          res_valid_o     = 1'b1;
          res_o.event_res = srd_pkg::EV_LINEERR;
        end
      end else if (cfg_i.sixbit_mode) begin
        if (rx_byte_i == srd_pkg::SIX_END) begin
          acc_d     = '0;
          bits_d    = '0;
          frame_end = 1'b1;
        end else if (rx_byte_i >= srd_pkg::SIX_BASE && rx_byte_i < srd_pkg::SIX_END) begin
          acc_d = acc_new;
          if (bits_sum >= 4'd8) begin
            bits_d    = bits_left;
            take_byte = 1'b1;
            byte_val  = 8'(acc_new >> bits_left);
          end else begin
            bits_d = bits_sum;
          end
        end
      end else begin
        if (rx_byte_i == cfg_i.end_char) begin
          esc_d     = 1'b0;
          frame_end = 1'b1;
        end else if (rx_byte_i == cfg_i.esc_char) begin
          esc_d = 1'b1;
        end else begin
          take_byte = 1'b1;
          // An escape code without a pending escape is plain data.
          if (rx_byte_i == cfg_i.esc_esc_char) begin
            if (esc_q) begin
              esc_d    = 1'b0;
              byte_val = cfg_i.esc_char;
            end
          end else if (rx_byte_i == cfg_i.esc_end_char) begin
            if (esc_q) begin
              esc_d    = 1'b0;
              byte_val = cfg_i.end_char;
            end
          end
        end
      end

      if (frame_end) begin
        res_valid_o        = 1'b1;
        res_o.event_res    = (!sticky_q && count_q > 17'd2) ? srd_pkg::EV_COMMIT
                                                             : srd_pkg::EV_DISCARD;
        res_o.frame_length = count_q;
        sticky_d           = 1'b0;
        count_d            = '0;
      end

      // Bytes of a frame already in error are dropped silently.
      if (take_byte && !sticky_q) begin
        res_valid_o = 1'b1;
        if (count_q < limit) begin
          count_d    = count_q + 17'd1;
          res_o.data = byte_val;
        end else begin
          sticky_d        = 1'b1;
          res_o.event_res = srd_pkg::EV_OVERRUN;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      esc_q    <= 1'b0;
      sticky_q <= 1'b0;
      acc_q    <= '0;
      bits_q   <= '0;
    end else begin
      count_q  <= count_d;
      esc_q    <= esc_d;
      sticky_q <= sticky_d;
      acc_q    <= acc_d;
      bits_q   <= bits_d;
    end
  end

endmodule

// ===== rtl/core/srd_out_stage.sv =====
// Result register of the SLIP receive deframer.
// Depends on srd_pkg.
module srd_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic                 res_valid_i,
  input  srd_pkg::srd_result_t res_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output srd_pkg::srd_result_t res_o
);

  logic                 valid_q, valid_d;
  srd_pkg::srd_result_t res_q;

  // The register can take a new result when empty or drained this cycle.
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = fire_i ? res_valid_i : (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/core/slip_receive_deframer.sv =====
// SLIP receive deframer, top level. Depends on srd_pkg, srd_cfg_regs, srd_in_stage,
// srd_decode, srd_out_stage and slip_receive_deframer_defines.svh.
// Path: input register, combinational decode, then result register.
// Throughput: one byte per cycle unless a result is blocked, set by the input register feeding the result register.
// Reset: rst_ni clears frame state, both valid flags and loads default configuration.
`include "slip_receive_deframer_defines.svh"
module slip_receive_deframer #(
  parameter int unsigned MAX_FRAME_CAP = srd_pkg::MAX_FRAME_CAP_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [srd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [srd_pkg::LEN_W-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  input  logic [0:0]                    s_axis_tuser,  // [0] line_error
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // [7:0] data, [24:8] frame_length
  output logic [2:0]                    m_axis_tuser   // [2:0] event_res
);

  srd_pkg::srd_cfg_t    cfg;
  srd_pkg::srd_result_t dec_res, out_res;
  logic                 in_valid, in_lerr, dec_valid, out_free, fire;
  logic [7:0]           in_byte;

  srd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  srd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .rx_byte_i    (s_axis_tdata),
    .line_error_i (s_axis_tuser[0]),
    .take_i       (fire),
    .valid_o      (in_valid),
    .rx_byte_o    (in_byte),
    .line_error_o (in_lerr)
  );

  assign fire = in_valid && out_free;

  srd_decode #(
    .MAX_FRAME_CAP (MAX_FRAME_CAP)
  ) u_dec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .fire_i       (fire),
    .rx_byte_i    (in_byte),
    .line_error_i (in_lerr),
    .res_valid_o  (dec_valid),
    .res_o        (dec_res)
  );

  srd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_valid_i (dec_valid),
    .res_i       (dec_res),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (out_res)
  );

  assign m_axis_tdata = {7'd0, out_res.frame_length, out_res.data};
  assign m_axis_tuser = out_res.event_res;

  // The input side stalls only while a byte waits behind a blocked result.
  `SRD_ASSERT_SAME(a_stall_cause, !s_axis_tready,
                   in_valid && m_axis_tvalid && !m_axis_tready,
                   "input stalled without a blocked result")
  `SRD_ASSERT_SAME(a_commit_len, m_axis_tvalid && m_axis_tuser == srd_pkg::EV_COMMIT,
                   m_axis_tdata[24:8] > 17'd2, "commit with a frame of two bytes or less")
  `SRD_ASSERT_SAME(a_data_no_len, m_axis_tvalid && m_axis_tuser == srd_pkg::EV_DATA,
                   m_axis_tdata[24:8] == 17'd0, "payload byte carries a length")
  `SRD_ASSERT_NEXT(a_fire_frees, fire && !dec_valid && m_axis_tvalid && m_axis_tready,
                   !m_axis_tvalid, "result register not emptied by a silent byte")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for slip_receive_deframer: byte stuffing and six-bit decoding.
// Depends on srd_pkg and the deframer RTL. A scoreboard class predicts each output
// transfer from the accepted line bytes, plain tasks drive the input side and a loop the output side.
import srd_pkg::*;

class slip_decode_model;
  // Register copies, at their reset values.
  bit             sixbit;
  bit [LEN_W-1:0] max_len;
  bit [7:0]       end_c;
  bit [7:0]       esc_c;
  bit [7:0]       esc_end_c;
  bit [7:0]       esc_esc_c;
  // Frame state.
  bit [LEN_W-1:0] byte_cnt;
  bit             esc_pend;
  bit             err_sticky;
  bit [13:0]      acc;
  bit [3:0]       held;

  srd_result_t expected_events[$];
  int mismatches;
  int seen[5];

  function new();
    sixbit    = 1'b0;
    max_len   = LEN_W'(1152);
    end_c     = 8'hC0;
    esc_c     = 8'hDB;
    esc_end_c = 8'hDC;
    esc_esc_c = 8'hDD;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] value);
    case (idx)
      CFG_SIXBIT_MODE:  sixbit    = value[0];
      CFG_MAX_FRAME:    max_len   = value;
      CFG_END_CHAR:     end_c     = value[7:0];
      CFG_ESC_CHAR:     esc_c     = value[7:0];
      CFG_ESC_END_CHAR: esc_end_c = value[7:0];
      CFG_ESC_ESC_CHAR: esc_esc_c = value[7:0];
      default: ;
    endcase
  endfunction

  function void push_event(srd_event_e ev, bit [7:0] d, bit [LEN_W-1:0] len);
    srd_result_t r;
    r.event_res    = ev;
    r.data         = d;
    r.frame_length = len;
    expected_events.push_back(r);
  endfunction

  function void close_frame();
    bit ok;
    ok = !err_sticky && byte_cnt > 2;
    push_event(ok ? EV_COMMIT : EV_DISCARD, 8'h00, byte_cnt);
    err_sticky = 1'b0;
    byte_cnt   = '0;
  endfunction

  function void store_payload(bit [7:0] b);
    bit [LEN_W-1:0] limit;
    limit = (max_len > MAX_FRAME_CAP_DEF) ? LEN_W'(MAX_FRAME_CAP_DEF) : max_len;
    if (err_sticky) return;
    if (byte_cnt < limit) begin
      byte_cnt = byte_cnt + 1'b1;
      push_event(EV_DATA, b, '0);
    end else begin
      err_sticky = 1'b1;
      push_event(EV_OVERRUN, 8'h00, '0);
    end
  endfunction

  // Called once for every byte transfer accepted on the input side.
  function void take_line_byte(bit [7:0] c, bit lerr);
    bit [7:0] b;
    b = c;
    if (lerr) begin
      // Only the first line error of a frame is reported.
      if (!err_sticky) begin
        err_sticky = 1'b1;
        push_event(EV_LINEERR, 8'h00, '0);
      end
    end else if (sixbit) begin
      if (c == SIX_END) begin
        acc  = '0;
        held = '0;
        close_frame();
      end else if (c >= SIX_BASE && c < SIX_END) begin
        acc  = {acc[7:0], 6'(c - SIX_BASE)};
        held = held + 4'd6;
        if (held >= 8) begin
          held = held - 4'd8;
          b = 8'(acc >> held);
          store_payload(b);
        end
      end
    end else if (c == end_c) begin
      esc_pend = 1'b0;
      close_frame();
    end else if (c == esc_c) begin
      esc_pend = 1'b1;
    end else begin
      // The escape flag survives ordinary bytes and is consumed only by an escape code or a frame end.
      if (c == esc_esc_c) begin
        if (esc_pend) begin
          esc_pend = 1'b0;
          b = esc_c;
        end
      end else if (c == esc_end_c) begin
        if (esc_pend) begin
          esc_pend = 1'b0;
          b = end_c;
        end
      end
      store_payload(b);
    end
  endfunction

  // Called once for every result transfer accepted on the output side.
  function void match_event(logic [31:0] tdata, logic [2:0] tuser);
    srd_result_t e;
    if (expected_events.size() == 0) begin
      $error("unexpected transfer: event_res %0d data 0x%02h frame_length %0d",
             tuser, tdata[7:0], tdata[24:8]);
      mismatches++;
      return;
    end
    e = expected_events.pop_front();
    seen[int'(e.event_res)]++;
    if (tuser !== e.event_res) begin
      $error("event_res: expected %0d, actual %0d", e.event_res, tuser);
      mismatches++;
    end
    if (tdata[7:0] !== e.data) begin
      $error("data: expected 0x%02h, actual 0x%02h", e.data, tdata[7:0]);
      mismatches++;
    end
    if (tdata[24:8] !== e.frame_length) begin
      $error("frame_length: expected %0d, actual %0d", e.frame_length, tdata[24:8]);
      mismatches++;
    end
    if (tdata[31:25] !== 7'd0) begin
      $error("tdata padding: expected 0x00, actual 0x%02h", tdata[31:25]);
      mismatches++;
    end
  endfunction
endclass

module tb_top;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 4;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [LEN_W-1:0]     cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;   // [7:0] rx_byte
  logic [0:0]           s_axis_tuser;   // [0] line_error
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [31:0]          m_axis_tdata;   // [7:0] data, [24:8] frame_length
  logic [2:0]           m_axis_tuser;   // [2:0] event_res

  slip_decode_model model;
  int idle_pct;
  int stall_pct;
  bit hold_req;
  int hold_left;
  int items_sent;
  int phases_run;

  slip_receive_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off counted here once requested.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      model.match_event(m_axis_tdata, m_axis_tuser);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] value);
    model.set_reg(idx, value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(bit six, logic [LEN_W-1:0] max_len, bit [7:0] end_c,
                            bit [7:0] esc_c, bit [7:0] esc_end_c, bit [7:0] esc_esc_c);
    write_reg(CFG_SIXBIT_MODE, LEN_W'(six));
    write_reg(CFG_MAX_FRAME, max_len);
    write_reg(CFG_END_CHAR, LEN_W'(end_c));
    write_reg(CFG_ESC_CHAR, LEN_W'(esc_c));
    write_reg(CFG_ESC_END_CHAR, LEN_W'(esc_end_c));
    write_reg(CFG_ESC_ESC_CHAR, LEN_W'(esc_esc_c));
  endtask

  // Stops offering, waits for every predicted transfer, then lets bytes that cause
  // no result clear the pipeline.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (model.expected_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Entered at a clock edge; returns at the edge where the transfer happened.
  task automatic send_byte(bit [7:0] b, bit lerr);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= lerr;
    do @(posedge clk_i); while (!s_axis_tready);
    model.take_line_byte(b, lerr);
    items_sent++;
  endtask

  task automatic send_stuffed_frame();
    int len;
    bit [7:0] p;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0: p = model.end_c;
        1: p = model.esc_c;
        2: p = model.esc_end_c;
        3: p = model.esc_esc_c;
        default: p = 8'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 99) < 3) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else if ($urandom_range(0, 99) < 10) begin
        // Raw noise: stray escapes, bare escape codes, early frame ends.
        send_byte(p, 1'b0);
      end else if (p == model.end_c) begin
        send_byte(model.esc_c, 1'b0);
        send_byte(model.esc_end_c, 1'b0);
      end else if (p == model.esc_c) begin
        send_byte(model.esc_c, 1'b0);
        send_byte(model.esc_esc_c, 1'b0);
      end else begin
        send_byte(p, 1'b0);
      end
    end
    if ($urandom_range(0, 99) < 95) send_byte(model.end_c, 1'b0);
  endtask

  task automatic send_sixbit_frame();
    int nchars;
    nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(0, 16);
    for (int i = 0; i < nchars; i++) begin
      if ($urandom_range(0, 99) < 3) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else if ($urandom_range(0, 99) < 8) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_byte(SIX_BASE + 8'($urandom_range(0, 63)), 1'b0);
      end
    end
    if ($urandom_range(0, 99) < 95) send_byte(SIX_END, 1'b0);
  endtask

  task automatic run_phase(int n_items, int idle, int stall);
    int target;
    target    = items_sent + n_items;
    idle_pct  = idle;
    stall_pct = stall;
    while (items_sent < target) begin
      if (model.sixbit) send_sixbit_frame();
      else send_stuffed_frame();
    end
    wait_idle();
    phases_run++;
  endtask

  initial begin
    model = new();
    idle_pct   = 0;
    stall_pct  = 0;
    hold_req   = 1'b0;
    hold_left  = 0;
    items_sent = 0;
    phases_run = 0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_SIXBIT_MODE;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tuser  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed byte stuffing with the reset configuration.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(model.esc_c, 1'b0);
    send_byte(model.esc_end_c, 1'b0);
    send_byte(model.esc_c, 1'b0);
    send_byte(model.esc_esc_c, 1'b0);
    send_byte(model.esc_end_c, 1'b0);       // no escape pending: plain byte
    send_byte(model.end_c, 1'b0);           // commit
    send_byte(8'h55, 1'b0);
    send_byte(model.end_c, 1'b0);           // too short: discard
    send_byte(8'h12, 1'b1);                 // line error reported
    send_byte(8'h34, 1'b1);                 // already errored: silent
    send_byte(8'h56, 1'b0);                 // dropped in errored frame
    send_byte(model.end_c, 1'b0);
    send_byte(model.esc_c, 1'b0);
    send_byte(8'h41, 1'b0);                 // escape stays pending over a plain byte
    send_byte(model.esc_end_c, 1'b0);
    send_byte(model.end_c, 1'b0);
    wait_idle();

    // Directed six-bit decoding, including ignored characters.
    write_reg(CFG_SIXBIT_MODE, LEN_W'(1));
    send_byte(SIX_BASE, 1'b0);
    send_byte(8'h6F, 1'b0);
    send_byte(8'h2F, 1'b0);
    send_byte(8'h4A, 1'b0);
    send_byte(8'h71, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(SIX_END, 1'b0);
    send_byte(SIX_END, 1'b0);
    wait_idle();

    // Back pressure: the receiver holds off while the sender keeps offering.
    set_config(1'b0, LEN_W'(1152), 8'hC0, 8'hDB, 8'hDC, 8'hDD);
    hold_req = 1'b1;
    run_phase(80, 0, 0);

    set_config(1'b0, LEN_W'(8), 8'hC0, 8'hDB, 8'hDC, 8'hDD);
    run_phase(100, 0, 0);
    set_config(1'b1, LEN_W'(8), 8'hC0, 8'hDB, 8'hDC, 8'hDD);
    run_phase(100, 76, 0);
    set_config(1'b0, {LEN_W{1'b1}}, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_phase(100, 0, 76);
    // Special bytes drawn from a tiny set so that they often coincide.
    set_config(1'b0, LEN_W'(12), 8'(8'h10 + $urandom_range(0, 2)),
               8'(8'h10 + $urandom_range(0, 2)), 8'(8'h10 + $urandom_range(0, 2)),
               8'(8'h10 + $urandom_range(0, 2)));
    run_phase(100, 33, 33);
    set_config(1'b1, LEN_W'(MAX_FRAME_CAP_DEF), 8'hC0, 8'hDB, 8'hDC, 8'hDD);
    run_phase(100, 33, 33);
    set_config(1'b0, LEN_W'(8), 8'hFF, 8'h00, 8'h80, 8'h7F);
    run_phase(100, 76, 76);

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("Summary: %0d line bytes over %0d random phases; checked %0d payload,",
             items_sent, phases_run, model.seen[EV_DATA]);
    $display("Summary: %0d commit, %0d discard, %0d overrun, %0d line-error transfers.",
             model.seen[EV_COMMIT], model.seen[EV_DISCARD], model.seen[EV_OVERRUN],
             model.seen[EV_LINEERR]);
    if (model.mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
